>>> rtl/block_bitmap_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block bitmap allocator checker
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Assert a property on a given clock, disabled while the active-low reset is low
`define BBA_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset
`define BBA_ASSERT(lbl, prop, msg) \
    `BBA_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and search helpers of the block bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    // Store geometry: one bit per block, wide rows for the free-block scan
    localparam int MAX_BLOCKS = 4096;
    localparam int IDX_W      = 12;
    localparam int LIMIT_W    = 13;
    localparam int ROW_W      = 256;
    localparam int ROWS       = MAX_BLOCKS / ROW_W;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int BIT_AW     = $clog2(ROW_W);
    localparam int BYTES_ROW  = ROW_W / 8;
    localparam int BYTE_AW    = $clog2(BYTES_ROW);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_BLOCKS);
    localparam logic [7:0]         FULL_BYTE   = 8'hFF;

    // Stream payload widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef logic [ROW_AW-1:0] t_row;
    typedef logic [ROW_W-1:0]  t_row_data;

    typedef enum logic [1:0] {
        REQ_TEST      = 2'd0,
        REQ_MARK_USED = 2'd1,
        REQ_MARK_FREE = 2'd2,
        REQ_FIND_FREE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_SCAN,
        S_DONE
    } t_state;

    // Command from the sequencer to the bitmap store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        t_row row;
    } t_mem_cmd;

    // Position of the lowest set flag among the bytes of a row
    function automatic logic [BYTE_AW-1:0] lowest_set_byte(input logic [BYTES_ROW-1:0] v);
        logic [BYTE_AW-1:0] r;
        r = '0;
        for (int i = BYTES_ROW - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BYTE_AW'(i);
            end
        end
        return r;
    endfunction

    // Position of the lowest clear bit of a byte
    function automatic logic [2:0] lowest_clear_bit(input logic [7:0] v);
        logic [2:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/bba_bitmap.sv
// ----------------------------------------------------------------------------
// bba_bitmap
// Usage bitmap store: wide rows, one shared address, registered read data.
// Rows never written since reset read as all free through per-row valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_bitmap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bba_pkg::t_mem_cmd  i_cmd,
    input  bba_pkg::t_row_data i_wr_data,
    output bba_pkg::t_row_data o_rd_data
);
    import bba_pkg::*;

    t_row_data       r_mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    t_row_data       r_rd_data;
    logic            r_rd_vld;

    // Write a row and remember that it now holds real contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.row] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_row_vld[i_cmd.row] <= 1'b1;
        end
    end

    // Read a row, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.row];
            r_rd_vld  <= r_row_vld[i_cmd.row];
        end
    end

    // An unwritten row reads as every block free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> rtl/block_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// Free-block bitmap with test, mark and first-fit find requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one beat per request; each request
//   gives exactly one result beat on the m_axis channel. The cfg channel
//   writes tracked_limit (always ready); write it only while the block idles.
//   Test and mark requests pass from accept to the result register through
//   one row read, one read-modify step and one result step. Find free streams
//   the 16 rows of 256 bits through the shared read port and a two-stage
//   zero search (byte flags, then bit), and the first free block found ends
//   the scan. An out-of-range index skips the row read and goes straight to
//   the result step. Only one request is in flight; s_axis_tready is high
//   while idle, so the next request can be taken in the cycle after the
//   result loads.
//   A new request is taken while the previous result still waits in the
//   output register. A stalled receiver holds m_axis beats and, once the
//   result register is full, holds the sequencer in its final step.
//   Reset (synchronous, active low) marks every block free, sets
//   tracked_limit to 4096 and drops any pending result. No clearing pass is
//   needed: per-row valid bits stand in for the cleared store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] req_type, [13:2] block_index
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [2] is_used, [14:3] free_index
    // Configuration: tracked_limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import bba_pkg::*;

    // Sequencer state
    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LIMIT_W-1:0] r_limit;

    // Scan issue counter
    t_row               r_issue_row, n_issue_row;
    logic               r_issue_on, n_issue_on;

    // Search pipeline
    logic               r_p1_vld;
    t_row               r_p1_row;
    logic               r_p2_vld;
    t_row               r_p2_row;
    logic               r_p2_any;
    logic [BYTE_AW-1:0] r_p2_byte;
    t_row_data          r_p2_data;

    // Result and output registers
    t_status            r_res_status, n_res_status;
    logic               r_res_used, n_res_used;
    logic [IDX_W-1:0]   r_res_free, n_res_free;
    logic               r_out_vld;
    logic [15:0]        r_out_data;

    // Store interface
    t_mem_cmd           mem_cmd;
    t_row_data          mem_wr_data;
    t_row_data          rd_data;

    logic               in_beat;
    logic               out_load;
    logic [LIMIT_W-1:0] lim_eff;
    logic               idx_out_of_range;
    logic [BYTES_ROW-1:0] byte_free;
    logic [7:0]         sel_byte;
    logic [2:0]         sel_bit;
    logic [IDX_W-1:0]   hit_pos;
    logic               scan_rd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Saturate the limit to the store size
    assign lim_eff = (r_limit > LIMIT_W'(MAX_BLOCKS)) ? LIMIT_W'(MAX_BLOCKS) : r_limit;
    assign idx_out_of_range = {1'b0, s_axis_tdata[13:2]} >= lim_eff;

    // Stage two: flag bytes of the row that hold a free block
    always_comb begin
        for (int j = 0; j < BYTES_ROW; j++) begin
            byte_free[j] = (rd_data[j*8 +: 8] != FULL_BYTE);
        end
    end

    // Stage three: pick the lowest free bit inside the chosen byte
    assign sel_byte = r_p2_data[{r_p2_byte, 3'b000} +: 8];
    assign sel_bit  = lowest_clear_bit(sel_byte);
    assign hit_pos  = {r_p2_row, r_p2_byte, sel_bit};

    assign scan_rd  = (r_state == S_SCAN) && r_issue_on;

    // Next state and store commands
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_issue_row  = r_issue_row;
        n_issue_on   = r_issue_on;
        n_res_status = r_res_status;
        n_res_used   = r_res_used;
        n_res_free   = r_res_free;
        mem_cmd      = '{rd_en: 1'b0, wr_en: 1'b0, row: r_idx[IDX_W-1 -: ROW_AW]};
        mem_wr_data  = rd_data;
        out_load     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_req        = t_req'(s_axis_tdata[1:0]);
                    n_idx        = s_axis_tdata[13:2];
                    n_res_status = STAT_OK;
                    n_res_used   = 1'b0;
                    n_res_free   = '0;
                    if (t_req'(s_axis_tdata[1:0]) == REQ_FIND_FREE) begin
                        n_issue_row = '0;
                        n_issue_on  = 1'b1;
                        n_state     = S_SCAN;
                    end else if (idx_out_of_range) begin
                        n_res_status = STAT_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end

            S_READ: begin
                mem_cmd.rd_en = 1'b1;
                n_state       = S_MODIFY;
            end

            S_MODIFY: begin
                case (r_req)
                    REQ_TEST: begin
                        n_res_used = rd_data[r_idx[BIT_AW-1:0]];
                    end
                    REQ_MARK_USED: begin
                        mem_cmd.wr_en                  = 1'b1;
                        mem_wr_data[r_idx[BIT_AW-1:0]] = 1'b1;
                    end
                    REQ_MARK_FREE: begin
                        mem_cmd.wr_en                  = 1'b1;
                        mem_wr_data[r_idx[BIT_AW-1:0]] = 1'b0;
                    end
                    default: begin
                        n_res_used = 1'b0;
                    end
                endcase
                n_state = S_DONE;
            end

            S_SCAN: begin
                // Issue one row read per cycle until every row is out or the scan ends
                if (r_issue_on) begin
                    mem_cmd.rd_en = 1'b1;
                    mem_cmd.row   = r_issue_row;
                    if (r_issue_row == t_row'(ROWS - 1)) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_issue_row = r_issue_row + 1'b1;
                    end
                end
                // Retire rows in order; the first free bit ends the scan
                if (r_p2_vld && r_p2_any) begin
                    n_issue_on = 1'b0;
                    n_state    = S_DONE;
                    if ({1'b0, hit_pos} < lim_eff) begin
                        n_res_free = hit_pos;
                    end else begin
                        n_res_status = STAT_EXHAUSTED;
                    end
                end else if (r_p2_vld && r_p2_row == t_row'(ROWS - 1)) begin
                    n_issue_on   = 1'b0;
                    n_res_status = STAT_EXHAUSTED;
                    n_state      = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_limit    <= LIMIT_RESET;
            r_issue_on <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue_on <= n_issue_on;
            r_p1_vld   <= scan_rd;
            r_p2_vld   <= r_p1_vld && (r_state == S_SCAN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_issue_row  <= n_issue_row;
        r_res_status <= n_res_status;
        r_res_used   <= n_res_used;
        r_res_free   <= n_res_free;
        r_p1_row     <= mem_cmd.row;
        r_p2_row     <= r_p1_row;
        r_p2_any     <= |byte_free;
        r_p2_byte    <= lowest_set_byte(byte_free);
        r_p2_data    <= rd_data;
        if (out_load) begin
            r_out_data <= {1'b0, r_res_free, r_res_used, r_res_status};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    bba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .i_wr_data (mem_wr_data),
        .o_rd_data (rd_data)
    );

endmodule

>>> rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the block bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_bitmap_allocator_core_assert.svh"

module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import bba_pkg::*;

    // Hold a result beat while the receiver stalls
    `BBA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result beat dropped under stall")

    // Go busy after taking a request
    `BBA_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

    // Never report an undefined status code
    `BBA_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3, "undefined status code")

    // Zero the other fields on a failed request
    `BBA_ASSERT(a_fail_fields, m_axis_tvalid && m_axis_tdata[1:0] != STAT_OK |-> m_axis_tdata[15:2] == 14'd0, "fields set on failure")

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/block_bitmap_allocator_checker.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_checker
// Watches the request, result and limit channels of the allocator, keeps a
// shadow bitmap and tracked-block limit, and checks every result beat against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,     // [1:0] req_type, [13:2] block_index
    // Result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,     // [1:0] status, [2] is_used, [14:3] free_index
    // Limit write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_data,
    // Status to the test top
    output int          o_pending,
    output int          o_errors
);
    import bba_pkg::*;

    // Result beat layout, lowest field in the lowest bits
    typedef struct packed {
        logic [IDX_W-1:0] free_index;
        logic             is_used;
        t_status          status;
    } t_alloc_result;

    localparam int PRINT_CAP = 100;

    logic [MAX_BLOCKS-1:0] shadow_used;
    logic [LIMIT_W-1:0]    shadow_limit;
    t_alloc_result         pending_results[$];
    int                    mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Print one line per mismatch, keep counting past the print cap
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] allocator mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Work out the result of one request and apply it to the shadow bitmap
    function automatic t_alloc_result predict_alloc_result(input t_req kind,
                                                           input logic [IDX_W-1:0] idx);
        t_alloc_result r;
        int            lim;
        int            first_free;
        r          = '0;
        r.status   = STAT_OK;
        lim        = (int'(shadow_limit) > MAX_BLOCKS) ? MAX_BLOCKS : int'(shadow_limit);
        first_free = MAX_BLOCKS;
        if (kind == REQ_FIND_FREE) begin
            for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
                if (!shadow_used[b]) begin
                    first_free = b;
                end
            end
            // a free block at or past the limit does not count
            if (first_free < lim) begin
                r.free_index = IDX_W'(first_free);
            end else begin
                r.status = STAT_EXHAUSTED;
            end
        end else if (int'(idx) >= lim) begin
            r.status = STAT_RANGE;
        end else begin
            case (kind)
                REQ_TEST: begin
                    r.is_used = shadow_used[idx];
                end
                REQ_MARK_USED: begin
                    shadow_used[idx] = 1'b1;
                end
                default: begin
                    shadow_used[idx] = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    // Track beats on every channel at the clock edge
    always @(posedge i_clk) begin
        t_alloc_result seen;
        t_alloc_result want;
        if (!i_rst_n) begin
            shadow_used  = '0;
            shadow_limit = LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                shadow_limit = i_cfg_data;
            end
            // compare the result beat before queuing a new request
            if (i_res_valid && i_res_ready) begin
                seen = t_alloc_result'(i_res_data[14:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%04h with nothing pending",
                                              i_res_data));
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status != want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  seen.status, want.status));
                    end
                    if (seen.is_used != want.is_used) begin
                        report_mismatch($sformatf("is_used %0b, want %0b",
                                                  seen.is_used, want.is_used));
                    end
                    if (seen.free_index != want.free_index) begin
                        report_mismatch($sformatf("free_index %0d, want %0d",
                                                  seen.free_index, want.free_index));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_results.push_back(predict_alloc_result(t_req'(i_req_data[1:0]),
                                                               i_req_data[13:2]));
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

>>> dv/block_bitmap_allocator_core_test.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core_test
// Drives test, mark and find-free requests into the allocator under several
// tracked-block limits and idle patterns, with a directed opening and an
// allocation-style random run; the checker beside the block scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator_core_test;
    import bba_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int STALL_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data = '0;

    int          pending_count;
    int          error_count;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_toggle = 1'b0;
    int          idle_cycles = 0;

    // Allocation bookkeeping for stimulus shaping
    logic [IDX_W-1:0] fill_cursor = '0;
    logic [IDX_W-1:0] freed_blocks[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    block_bitmap_allocator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    block_bitmap_allocator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending_count),
        .o_errors    (error_count)
    );

    // Result receiver: random stalls, plus a long hold-off on request
    initial begin
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request beat, with random idle cycles ahead of it
    task automatic send_req(input t_req kind, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, kind};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and hold until every predicted result has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Write tracked_limit once the block has gone idle
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly allocator-like traffic: grow a used run, punch and refill holes
    task automatic send_random_item();
        int               pick;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 55) begin
            if (freed_blocks.size() > 0 && $urandom_range(3) == 0) begin
                idx = freed_blocks.pop_front();
            end else begin
                idx = fill_cursor;
                fill_cursor++;
            end
            send_req(REQ_MARK_USED, idx);
        end else if (pick < 70) begin
            send_req(REQ_FIND_FREE, IDX_W'($urandom));
        end else if (pick < 82) begin
            idx = IDX_W'($urandom_range(int'(fill_cursor) + 8));
            send_req(REQ_TEST, idx);
        end else if (pick < 90) begin
            idx = IDX_W'($urandom_range(int'(fill_cursor)));
            freed_blocks.push_back(idx);
            send_req(REQ_MARK_FREE, idx);
        end else begin
            send_req(t_req'($urandom_range(3)), IDX_W'($urandom));
        end
    endtask

    initial begin
        int lim_near;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty bitmap, edges of the index range, reset limit
        send_req(REQ_FIND_FREE, 12'd0);
        send_req(REQ_TEST, 12'd0);
        send_req(REQ_MARK_USED, 12'd0);
        send_req(REQ_TEST, 12'd0);
        send_req(REQ_FIND_FREE, 12'hFFF);
        send_req(REQ_MARK_USED, 12'hFFF);
        send_req(REQ_TEST, 12'hFFF);
        send_req(REQ_MARK_FREE, 12'hFFF);
        send_req(REQ_TEST, 12'hFFF);
        send_req(REQ_MARK_FREE, 12'd5);

        // Zero limit: everything out of range, find free exhausted
        write_limit(13'd0);
        send_req(REQ_TEST, 12'd0);
        send_req(REQ_MARK_USED, 12'd7);
        send_req(REQ_FIND_FREE, 12'd0);
        send_req(REQ_MARK_FREE, 12'd0);

        // Limit past the store saturates
        write_limit(13'h1FFF);
        send_req(REQ_MARK_USED, 12'hFFF);
        send_req(REQ_TEST, 12'hFFF);

        // Small limit: fill below it, free bit above it must not count
        write_limit(13'd4);
        send_req(REQ_MARK_USED, 12'd1);
        send_req(REQ_MARK_USED, 12'd2);
        send_req(REQ_MARK_USED, 12'd3);
        send_req(REQ_TEST, 12'd4);
        send_req(REQ_FIND_FREE, 12'd0);
        send_req(REQ_MARK_FREE, 12'd2);
        send_req(REQ_FIND_FREE, 12'd0);
        send_req(REQ_MARK_USED, 12'd2);

        // Random, no idling, one long receiver hold-off mid-phase
        write_limit(13'd4096);
        for (int n = 0; n < 200; n++) begin
            if (n == 100) begin
                hold_toggle <= ~hold_toggle;
            end
            send_random_item();
        end

        // Random, sender idles often, saturated limit
        write_limit(13'h1FFF);
        tx_idle_pct = 67;
        repeat (170) send_random_item();

        // Random, receiver stalls often, limit close to the used run
        tx_idle_pct  = 0;
        rx_stall_pct = 67;
        lim_near = int'(fill_cursor) + int'($urandom_range(8)) - 4;
        if (lim_near < 0) begin
            lim_near = 0;
        end
        write_limit(LIMIT_W'(lim_near));
        repeat (150) send_random_item();

        // Random, both sides idle, with a full drain part way through
        write_limit(13'd4097);
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        for (int n = 0; n < 180; n++) begin
            if (n == 90) begin
                wait_drained();
            end
            send_random_item();
        end

        // Let the last results come in, then give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
